>>> rtl/shs_pkg.sv
`default_nettype none

package shs_pkg;

  localparam int KEY_W   = 8;
  localparam int WORD_W  = 64;
  localparam int BASE_W  = 11;
  localparam int DEPTH_W = 11;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_IGNORE = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_KEY   = 3'd1,
    ST_BAD_BASE  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_UNDERFLOW = 3'd4
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;       // take the input transaction and start the first reads
    logic entry_lookup;  // read the entry that the key's slot points at
    logic commit;        // update state and load the result register
  } shs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_entry;    // lookup hit: the entry store must still be read
    logic out_free;      // the result register can take a new result
  } shs_sts_t;

endpackage

`default_nettype wire

>>> rtl/shs_ctrl.sv
`default_nettype none

module shs_ctrl
  import shs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  shs_sts_t sts,
  output shs_cmd_t cmd,
  output logic     busy
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ENTRY
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        if (sts.need_entry) begin
          cmd.entry_lookup = 1'b1;
          state_nxt        = S_ENTRY;
        end else if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ENTRY: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

>>> rtl/shs_dpath.sv
`default_nettype none

module shs_dpath
  import shs_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int NUM_OPS     = 64
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  shs_cmd_t           cmd,
  output shs_sts_t           sts,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [WORD_W-1:0]  in_handler_word,
  input  logic [WORD_W-1:0]  in_env_word,
  input  logic [BASE_W-1:0]  in_activation_base,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [STAT_W-1:0]  out_status,
  output logic               out_found,
  output logic [WORD_W-1:0]  out_handler_out,
  output logic [WORD_W-1:0]  out_env_out,
  output logic [DEPTH_W-1:0] out_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int KW = $clog2(NUM_OPS);
  // Entry word: {key, hidden index, hidden valid, handler, env}.
  localparam int EW = KW + AW + 1 + 2 * WORD_W;
  localparam logic [KEY_W:0] NUM_OPS_K = (KEY_W + 1)'(NUM_OPS);
  localparam logic [CW-1:0]  FULL_CNT  = CW'(STACK_DEPTH);

  // Live entry count.
  logic [CW-1:0] count_r, count_nxt;

  // Captured transaction.
  op_t               op_r;
  logic [KW-1:0]     key_r;
  logic [WORD_W-1:0] hw_r, ew_r;
  status_t           status_r;

  // Key table: index store plus one valid flop per key.
  logic [AW-1:0]      slot_mem [NUM_OPS];
  logic [NUM_OPS-1:0] slot_vld_r;
  logic [AW-1:0]      slot_idx_q;
  logic               slot_vld_q;

  // Entry store.
  logic [EW-1:0] ent_mem [STACK_DEPTH];
  logic [EW-1:0] ent_q;

  // Result register.
  logic               out_valid_r;
  logic [STAT_W-1:0]  out_status_r;
  logic               out_found_r;
  logic [WORD_W-1:0]  out_handler_r, out_env_r;
  logic [DEPTH_W-1:0] out_depth_r;

  op_t             op_in;
  logic            key_ok, base_ok, full, empty;
  status_t         status_cap;
  logic            ok, hit, push_ok, pop_ok;
  logic            slot_we;
  logic [KW-1:0]   slot_waddr;
  logic [AW-1:0]   slot_wdata;
  logic            ent_re;
  logic [AW-1:0]   ent_raddr;
  logic [KW-1:0]   pop_key;
  logic [AW-1:0]   pop_hid_idx;
  logic            pop_hid_vld;
  logic [WORD_W-1:0] ent_handler, ent_env;

  // Checks are made against the count at capture; it cannot change before commit.
  assign op_in   = op_t'(in_operation);
  assign key_ok  = {1'b0, in_key} < NUM_OPS_K;
  assign base_ok = 32'(in_activation_base) <= 32'(count_r);
  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);

  always_comb begin
    status_cap = ST_OK;
    unique case (op_in)
      OP_PUSH: begin
        priority if (!key_ok) status_cap = ST_BAD_KEY;
        else if (!base_ok)    status_cap = ST_BAD_BASE;
        else if (full)        status_cap = ST_OVERFLOW;
        else                  status_cap = ST_OK;
      end
      OP_POP:    status_cap = empty ? ST_UNDERFLOW : ST_OK;
      OP_LOOKUP: status_cap = key_ok ? ST_OK : ST_BAD_KEY;
      OP_IGNORE: status_cap = ST_OK;
      default:   status_cap = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_in;
      key_r    <= in_key[KW-1:0];
      hw_r     <= in_handler_word;
      ew_r     <= in_env_word;
      status_r <= status_cap;
    end
  end

  assign ok  = (status_r == ST_OK);
  assign hit = (op_r == OP_LOOKUP) && ok && slot_vld_q;

  assign push_ok = cmd.commit && (op_r == OP_PUSH) && ok;
  assign pop_ok  = cmd.commit && (op_r == OP_POP) && ok;

  assign pop_key     = ent_q[EW-1 -: KW];
  assign pop_hid_idx = ent_q[2*WORD_W+1 +: AW];
  assign pop_hid_vld = ent_q[2*WORD_W];
  assign ent_handler = ent_q[WORD_W +: WORD_W];
  assign ent_env     = ent_q[WORD_W-1:0];

  // Key table: a push points the key at the new top, a pop restores what it hid.
  assign slot_we    = push_ok || pop_ok;
  assign slot_waddr = push_ok ? key_r : pop_key;
  assign slot_wdata = push_ok ? count_r[AW-1:0] : pop_hid_idx;

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (cmd.capture) begin
      slot_idx_q <= slot_mem[in_key[KW-1:0]];
      slot_vld_q <= key_ok && slot_vld_r[in_key[KW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
    end else if (push_ok) begin
      slot_vld_r[key_r] <= 1'b1;
    end else if (pop_ok) begin
      slot_vld_r[pop_key] <= pop_hid_vld;
    end
  end

  // The capture read fetches the top entry for a pop; a lookup hit reads again.
  assign ent_re    = cmd.capture || cmd.entry_lookup;
  assign ent_raddr = cmd.capture ? AW'(count_r - CW'(1)) : slot_idx_q;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      ent_mem[count_r[AW-1:0]] <= {key_r, slot_idx_q, slot_vld_q, hw_r, ew_r};
    end
    if (ent_re) begin
      ent_q <= ent_mem[ent_raddr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r  <= status_r;
      out_found_r   <= hit;
      out_handler_r <= hit ? ent_handler : '0;
      out_env_r     <= hit ? ent_env : '0;
      out_depth_r   <= DEPTH_W'(count_nxt);
    end
  end

  assign sts.need_entry = hit;
  assign sts.out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_handler_out = out_handler_r;
  assign out_env_out     = out_env_r;
  assign out_depth       = out_depth_r;

endmodule

`default_nettype wire

>>> rtl/scoped_handler_stack.sv
`default_nettype none

// Stack of handler entries with a per-key table that always names the
// innermost live entry for each key. Push, pop, ignore and a lookup that
// misses capture and then commit; a lookup that hits reads the entry store
// in between. The steps follow the chain of registered memory reads: the key
// table is read first, and a hit then reads the entry store at the index it
// found. The next input transaction is taken while an earlier result still
// waits in the output register. The key table's valid bits reset at once,
// so no clearing pass is needed and the block is ready right after reset.

module scoped_handler_stack
  import shs_pkg::*;
#(
  parameter int STACK_DEPTH = 1024,
  parameter int NUM_OPS     = 64
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [WORD_W-1:0]  in_handler_word,
  input  logic [WORD_W-1:0]  in_env_word,
  input  logic [BASE_W-1:0]  in_activation_base,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [STAT_W-1:0]  out_status,
  output logic               out_found,
  output logic [WORD_W-1:0]  out_handler_out,
  output logic [WORD_W-1:0]  out_env_out,
  output logic [DEPTH_W-1:0] out_depth
);

  shs_cmd_t cmd;
  shs_sts_t sts;
  logic     busy;

  shs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .busy     (busy)
  );

  shs_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .NUM_OPS     (NUM_OPS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_operation),
    .in_key             (in_key),
    .in_handler_word    (in_handler_word),
    .in_env_word        (in_env_word),
    .in_activation_base (in_activation_base),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found          (out_found),
    .out_handler_out    (out_handler_out),
    .out_env_out        (out_env_out),
    .out_depth          (out_depth)
  );

  assign in_stall = busy;

endmodule

`default_nettype wire

>>> rtl/shs_checker.sv
`default_nettype none

module shs_checker
  import shs_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [STAT_W-1:0]  out_status,
  input wire logic               out_found,
  input wire logic [WORD_W-1:0]  out_handler_out,
  input wire logic [WORD_W-1:0]  out_env_out,
  input wire logic [DEPTH_W-1:0] out_depth
);

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_handler_out) && $stable(out_env_out) && $stable(out_depth))
    else $error("stalled result changed");

  // One transaction at a time: the input side is held off right after a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a transaction");

  // A hit only comes with a good status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK)
    else $error("found with a failing status");

  // Without a hit the words are zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_handler_out == '0 && out_env_out == '0)
    else $error("nonzero words without a hit");

endmodule

bind scoped_handler_stack shs_checker u_shs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_found       (out_found),
  .out_handler_out (out_handler_out),
  .out_env_out     (out_env_out),
  .out_depth       (out_depth)
);

`default_nettype wire
